[design/byte_string_repr_escaper_defines.svh]
// assertion macros shared by the checker of the byte string repr escaper
// no dependencies; expects clk_i and rst_ni in the scope of use
`ifndef BYTE_STRING_REPR_ESCAPER_DEFINES_SVH
`define BYTE_STRING_REPR_ESCAPER_DEFINES_SVH

// same-cycle implication
`define BSRE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSRE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/bsre_pkg.sv]
// types, constants and helpers for the byte string repr escaper
// used by every module of the block; no dependencies
`timescale 1ns / 1ps

package bsre_pkg;

  localparam int MAX_LEN = 4096;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int LEN_W   = 15;
  localparam int CH_W    = 7;
  localparam int MAX_RES = 7;
  localparam int RES_W   = $clog2(MAX_RES + 1);

  typedef enum logic [0:0] {
    REQ_SCAN = 1'b0,
    REQ_EMIT = 1'b1
  } req_type_e;

  typedef enum logic [0:0] {
    KIND_CHAR = 1'b0,
    KIND_LEN  = 1'b1
  } kind_e;

  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_LF    = 8'h0a;
  localparam logic [7:0] BYTE_CR    = 8'h0d;
  localparam logic [7:0] BYTE_DQ    = 8'h22;
  localparam logic [7:0] BYTE_SQ    = 8'h27;
  localparam logic [7:0] BYTE_BSL   = 8'h5c;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_DEL   = 8'h7f;

  localparam logic [CH_W-1:0] CH_B   = 7'h62;
  localparam logic [CH_W-1:0] CH_DQ  = 7'h22;
  localparam logic [CH_W-1:0] CH_SQ  = 7'h27;
  localparam logic [CH_W-1:0] CH_BSL = 7'h5c;
  localparam logic [CH_W-1:0] CH_T   = 7'h74;
  localparam logic [CH_W-1:0] CH_N   = 7'h6e;
  localparam logic [CH_W-1:0] CH_R   = 7'h72;
  localparam logic [CH_W-1:0] CH_X   = 7'h78;

  localparam logic [LEN_W-1:0] LEN_BASE = 15'd3;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
    logic       is_last;
    logic       empty_req;
  } req_t;

  typedef struct packed {
    logic             kind;
    logic [CH_W-1:0]  ch;
    logic [LEN_W-1:0] out_length;
    logic             quote_double;
    logic             overflow;
    logic             last_of_run;
  } rsp_t;

  // scan report toward the result register
  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic             quote_double;
    logic             overflow;
  } scan_rpt_t;

  // characters of one emit transaction, slot 0 first
  typedef struct packed {
    logic [RES_W-1:0]              cnt;
    logic [MAX_RES-1:0][CH_W-1:0] chars;
  } emit_burst_t;

  // everything the result register loads for one transaction
  typedef struct packed {
    logic                          kind;
    logic [RES_W-1:0]              cnt;
    logic [MAX_RES-1:0][CH_W-1:0] chars;
    logic [LEN_W-1:0]              length;
    logic                          quote_double;
    logic                          overflow;
  } burst_t;

  function automatic logic [CH_W-1:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return CH_W'(7'h30 + {3'b000, nib});
    end
    return CH_W'(7'h57 + {3'b000, nib});
  endfunction

endpackage

[design/bsre_in_reg.sv]
// input register of the byte string repr escaper
// depends on bsre_pkg
`timescale 1ns / 1ps

module bsre_in_reg import bsre_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  input  logic take_i,
  output logic valid_o,
  output req_t data_o
);

  logic valid_q, valid_d;
  req_t data_q;

  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[design/bsre_scan.sv]
// scan pass: quote counts, length sum, overflow and quote choice
// depends on bsre_pkg
`timescale 1ns / 1ps

module bsre_scan import bsre_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  req_t      req_i,
  input  logic      smart_quotes_i,
  output logic      use_dq_o,
  output scan_rpt_t rpt_o
);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);

  logic [CNT_W-1:0] sq_q, sq_d, dqc_q, dqc_d, seen_q, seen_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             ovf_q, ovf_d, use_dq_q, use_dq_d;

  logic [CNT_W-1:0] sq_n, dqc_n, seen_n;
  logic [LEN_W-1:0] len_n;
  logic             ovf_n, dq_pick;
  logic [2:0]       incr;
  logic [LEN_W:0]   sum;
  logic [7:0]       c;

  assign c = req_i.data_byte;

  always_comb begin
    sq_n   = sq_q;
    dqc_n  = dqc_q;
    seen_n = seen_q;
    len_n  = len_q;
    ovf_n  = ovf_q;
    incr   = 3'd1;
    if (c == BYTE_SQ || c == BYTE_DQ) begin
      incr = 3'd1;
    end else if (c == BYTE_BSL || c == BYTE_TAB || c == BYTE_LF || c == BYTE_CR) begin
      incr = 3'd2;
    end else if (c < BYTE_SPACE || c >= BYTE_DEL) begin
      incr = 3'd4;
    end
    if (!req_i.empty_req) begin
      if (seen_q == MAX_CNT) begin
        ovf_n = 1'b1;
      end else begin
        seen_n = seen_q + CNT_W'(1);
        len_n  = len_q + LEN_W'(incr);
        if (c == BYTE_SQ) begin
          sq_n = sq_q + CNT_W'(1);
        end
        if (c == BYTE_DQ) begin
          dqc_n = dqc_q + CNT_W'(1);
        end
      end
    end
  end

  assign dq_pick = smart_quotes_i && (sq_n != '0) && (dqc_n == '0);
  assign sum     = {1'b0, len_n} + (dq_pick ? '0 : (LEN_W + 1)'(sq_n));

  always_comb begin
    rpt_o.length       = sum[LEN_W] ? '1 : sum[LEN_W-1:0];
    rpt_o.quote_double = dq_pick;
    rpt_o.overflow     = ovf_n;
  end

  always_comb begin
    sq_d     = sq_q;
    dqc_d    = dqc_q;
    seen_d   = seen_q;
    len_d    = len_q;
    ovf_d    = ovf_q;
    use_dq_d = use_dq_q;
    if (en_i) begin
      if (req_i.is_last || req_i.empty_req) begin
        sq_d     = '0;
        dqc_d    = '0;
        seen_d   = '0;
        len_d    = LEN_BASE;
        ovf_d    = 1'b0;
        use_dq_d = dq_pick;
      end else begin
        sq_d   = sq_n;
        dqc_d  = dqc_n;
        seen_d = seen_n;
        len_d  = len_n;
        ovf_d  = ovf_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q     <= '0;
      dqc_q    <= '0;
      seen_q   <= '0;
      len_q    <= LEN_BASE;
      ovf_q    <= 1'b0;
      use_dq_q <= 1'b0;
    end else begin
      sq_q     <= sq_d;
      dqc_q    <= dqc_d;
      seen_q   <= seen_d;
      len_q    <= len_d;
      ovf_q    <= ovf_d;
      use_dq_q <= use_dq_d;
    end
  end

  assign use_dq_o = use_dq_q;

endmodule

[design/bsre_emit.sv]
// emit pass: escapes one byte and frames the literal with b and quotes
// depends on bsre_pkg
`timescale 1ns / 1ps

module bsre_emit import bsre_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  req_t        req_i,
  input  logic        use_dq_i,
  output emit_burst_t burst_o
);

  logic                  started_q, started_d;
  logic [CH_W-1:0]       q;
  logic [7:0]            c;
  logic [3:0][CH_W-1:0] body;
  logic [RES_W-1:0]      pre_cnt, body_cnt, k;
  logic                  suf;

  assign c   = req_i.data_byte;
  assign q   = use_dq_i ? CH_DQ : CH_SQ;
  assign suf = req_i.is_last || req_i.empty_req;

  always_comb begin
    body     = '0;
    body_cnt = '0;
    if (!req_i.empty_req) begin
      if (c == {1'b0, q} || c == BYTE_BSL) begin
        body     = {14'h0, c[6:0], CH_BSL};
        body_cnt = RES_W'(2);
      end else if (c == BYTE_TAB) begin
        body     = {14'h0, CH_T, CH_BSL};
        body_cnt = RES_W'(2);
      end else if (c == BYTE_LF) begin
        body     = {14'h0, CH_N, CH_BSL};
        body_cnt = RES_W'(2);
      end else if (c == BYTE_CR) begin
        body     = {14'h0, CH_R, CH_BSL};
        body_cnt = RES_W'(2);
      end else if (c < BYTE_SPACE || c >= BYTE_DEL) begin
        body     = {hex_char(c[3:0]), hex_char(c[7:4]), CH_X, CH_BSL};
        body_cnt = RES_W'(4);
      end else begin
        body     = {21'h0, c[6:0]};
        body_cnt = RES_W'(1);
      end
    end
  end

  assign pre_cnt = started_q ? '0 : RES_W'(2);

  always_comb begin
    k             = '0;
    burst_o.chars = '0;
    for (int i = 0; i < MAX_RES; i++) begin
      k = RES_W'(i) - pre_cnt;
      if (RES_W'(i) < pre_cnt) begin
        burst_o.chars[i] = (i == 0) ? CH_B : q;
      end else if (k < body_cnt) begin
        burst_o.chars[i] = body[k[1:0]];
      end else begin
        burst_o.chars[i] = q;
      end
    end
    burst_o.cnt = pre_cnt + body_cnt + RES_W'(suf);
  end

  always_comb begin
    started_d = started_q;
    if (en_i) begin
      started_d = !suf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
    end else begin
      started_q <= started_d;
    end
  end

endmodule

[design/bsre_out_seq.sv]
// result register: holds one transaction's results, handing one out per ready cycle
// depends on bsre_pkg
`timescale 1ns / 1ps

module bsre_out_seq import bsre_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   load_i,
  input  burst_t burst_i,
  output logic   free_o,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output rsp_t   out_data_o
);

  logic                          valid_q, valid_d;
  logic [RES_W-1:0]              cnt_q, cnt_d;
  logic                          kind_q, qd_q, ovf_q;
  logic [MAX_RES-1:0][CH_W-1:0] chars_q;
  logic [LEN_W-1:0]              len_q;
  logic                          fire, at_last;

  assign fire    = valid_q && out_ready_i;
  assign at_last = (cnt_q == RES_W'(1));
  assign free_o  = !valid_q || (out_ready_i && at_last);

  always_comb begin
    valid_d = valid_q;
    cnt_d   = cnt_q;
    if (load_i) begin
      valid_d = 1'b1;
      cnt_d   = burst_i.cnt;
    end else if (fire) begin
      valid_d = !at_last;
      cnt_d   = cnt_q - RES_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      kind_q  <= burst_i.kind;
      chars_q <= burst_i.chars;
      len_q   <= burst_i.length;
      qd_q    <= burst_i.quote_double;
      ovf_q   <= burst_i.overflow;
    end else if (fire) begin
      chars_q <= chars_q >> CH_W;
    end
  end

  always_comb begin
    out_data_o.kind         = kind_q;
    out_data_o.ch           = (kind_q == KIND_LEN) ? '0 : chars_q[0];
    out_data_o.out_length   = (kind_q == KIND_LEN) ? len_q : '0;
    out_data_o.quote_double = qd_q;
    out_data_o.overflow     = (kind_q == KIND_LEN) ? ovf_q : 1'b0;
    out_data_o.last_of_run  = at_last;
  end

  assign out_valid_o = valid_q;

endmodule

[design/byte_string_repr_escaper.sv]
// Byte string repr escaper: turns a byte string into its b'...' literal in a scan pass
// (quote counts, length report) and an emit pass (escaped characters). Each transaction
// is registered, worked combinationally and loaded into a result register that hands
// out one result per cycle while out_ready_i is high. The results per transaction are
// none for a scan byte that is not last, one for a scan end or a plain byte, two for a
// simple escape, four for \xHH, plus two for the opening b and quote and one for the
// closing quote. While the result register drains, a transaction with results waits in
// the input register and holds off the input until the last result is taken; a scan
// byte that is not last moves on without waiting. Results pass the input register, then
// the result register. Depends on bsre_pkg and the bsre_* submodules.
`timescale 1ns / 1ps

module byte_string_repr_escaper import bsre_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_data_o,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i
);

  logic        smart_q;
  logic        iq_valid, take, zero_res, burst_free, is_scan, use_dq;
  req_t        iq_data;
  scan_rpt_t   rpt;
  emit_burst_t ebur;
  burst_t      bur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smart_q <= 1'b1;
    end else if (cfg_we_i) begin
      smart_q <= cfg_wdata_i;
    end
  end

  bsre_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .take_i     (take),
    .valid_o    (iq_valid),
    .data_o     (iq_data)
  );

  assign is_scan  = (iq_data.req_type == REQ_SCAN);
  assign zero_res = is_scan && !(iq_data.is_last || iq_data.empty_req);
  assign take     = iq_valid && (zero_res || burst_free);

  bsre_scan u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (take && is_scan),
    .req_i          (iq_data),
    .smart_quotes_i (smart_q),
    .use_dq_o       (use_dq),
    .rpt_o          (rpt)
  );

  bsre_emit u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (take && !is_scan),
    .req_i    (iq_data),
    .use_dq_i (use_dq),
    .burst_o  (ebur)
  );

  always_comb begin
    if (is_scan) begin
      bur.kind         = KIND_LEN;
      bur.cnt          = RES_W'(1);
      bur.chars        = '0;
      bur.length       = rpt.length;
      bur.quote_double = rpt.quote_double;
      bur.overflow     = rpt.overflow;
    end else begin
      bur.kind         = KIND_CHAR;
      bur.cnt          = ebur.cnt;
      bur.chars        = ebur.chars;
      bur.length       = '0;
      bur.quote_double = use_dq;
      bur.overflow     = 1'b0;
    end
  end

  bsre_out_seq u_out_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take && !zero_res),
    .burst_i     (bur),
    .free_o      (burst_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[design/bsre_checker.sv]
// port-level checker for the byte string repr escaper, bound to the top level
// depends on bsre_pkg and byte_string_repr_escaper_defines.svh
`timescale 1ns / 1ps
`include "byte_string_repr_escaper_defines.svh"

module bsre_checker import bsre_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_ready_i,
  input rsp_t out_data_o
);

  `BSRE_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o,
                    "result dropped while stalled")
  `BSRE_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(out_data_o),
                    "stalled result changed")
  `BSRE_ASSERT_NOW(a_len_single, out_valid_o && (out_data_o.kind == KIND_LEN),
                   out_data_o.last_of_run && (out_data_o.ch == '0),
                   "length report not a single result")
  `BSRE_ASSERT_NEXT(a_run_continues, out_valid_o && out_ready_i && !out_data_o.last_of_run,
                    out_valid_o && (out_data_o.kind == KIND_CHAR),
                    "character run broken")

endmodule

bind byte_string_repr_escaper bsre_checker u_bsre_checker (.*);
